FILE: src/bpc_pkg.sv
// Shared types and constants of the button press classifier.
package bpc_pkg;

	localparam int LIMIT_W = 24;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_INDEX_W = 2;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [LIMIT_W-1:0] limit_t;

	localparam cfg_index_t REG_DEBOUNCE_LIMIT = 2'd0;
	localparam cfg_index_t REG_LONG_PRESS_LIMIT = 2'd1;
	localparam cfg_index_t REG_LONG_PRESS_ENABLE = 2'd2;

	localparam limit_t RESET_DEBOUNCE = 24'd12000;
	localparam limit_t RESET_LONG = 24'd600000;
	localparam logic [3:0] RESET_ENABLE = 4'd5;

	typedef struct packed {
		logic we;
		cfg_index_t index;
		cfg_data_t data;
	} cfg_wr_t;

endpackage

FILE: src/bpc_tick_if.sv
// Channel that carries one poll tick: button levels and timestamp.
interface bpc_tick_if #(
	parameter int NUM_BUTTONS = 4,
	parameter int TIME_BITS = 48
);
	logic valid;
	logic ready;
	logic [NUM_BUTTONS-1:0] pin_levels;
	logic [TIME_BITS-1:0] now_us;

	modport source (output valid, output pin_levels, output now_us, input ready);
	modport sink (input valid, input pin_levels, input now_us, output ready);
endinterface

FILE: src/bpc_event_if.sv
// Channel that carries one classified button event.
interface bpc_event_if #(
	parameter int BUTTON_W = 2
);
	logic valid;
	logic ready;
	logic [BUTTON_W-1:0] button;
	logic long_press;
	logic last;

	modport source (output valid, output button, output long_press, output last, input ready);
	modport sink (input valid, input button, input long_press, input last, output ready);
endinterface

FILE: src/bpc_cfg_regs.sv
// Configuration registers: debounce limit, long-press limit and enable mask.
module bpc_cfg_regs #(
	parameter int NUM_BUTTONS = 4
) (
	input logic clk,
	input logic arst_n,
	input bpc_pkg::cfg_wr_t wr,
	output bpc_pkg::limit_t debounce_limit,
	output bpc_pkg::limit_t long_press_limit,
	output logic [NUM_BUTTONS-1:0] long_press_enable
);

	bpc_pkg::limit_t debounce_q;
	bpc_pkg::limit_t long_q;
	logic [NUM_BUTTONS-1:0] enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= bpc_pkg::RESET_DEBOUNCE;
			long_q <= bpc_pkg::RESET_LONG;
			enable_q <= NUM_BUTTONS'(bpc_pkg::RESET_ENABLE);
		end else if (wr.we) begin
			case (wr.index)
				bpc_pkg::REG_DEBOUNCE_LIMIT: debounce_q <= wr.data[bpc_pkg::LIMIT_W-1:0];
				bpc_pkg::REG_LONG_PRESS_LIMIT: long_q <= wr.data[bpc_pkg::LIMIT_W-1:0];
				bpc_pkg::REG_LONG_PRESS_ENABLE: enable_q <= wr.data[NUM_BUTTONS-1:0];
				default: ;
			endcase
		end
	end

	assign debounce_limit = debounce_q;
	assign long_press_limit = long_q;
	assign long_press_enable = enable_q;

endmodule

FILE: src/bpc_classify.sv
// Input register, press state and release classification for one tick.
module bpc_classify #(
	parameter int NUM_BUTTONS = 4,
	parameter int TIME_BITS = 48
) (
	input logic clk,
	input logic arst_n,
	input logic load,
	input logic [NUM_BUTTONS-1:0] pin_levels,
	input logic [TIME_BITS-1:0] now_us,
	input logic advance,
	input bpc_pkg::limit_t debounce_limit,
	input bpc_pkg::limit_t long_press_limit,
	input logic [NUM_BUTTONS-1:0] long_press_enable,
	output logic valid_s1,
	output logic [NUM_BUTTONS-1:0] ev_mask,
	output logic [NUM_BUTTONS-1:0] ev_long
);

	logic [NUM_BUTTONS-1:0] levels_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic valid_q;
	logic [NUM_BUTTONS-1:0] was_pressed_q;
	logic [TIME_BITS-1:0] press_time_q [NUM_BUTTONS];
	logic [TIME_BITS-1:0] held [NUM_BUTTONS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (advance) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			levels_s1 <= pin_levels;
			now_s1 <= now_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_pressed_q <= '0;
		end else if (advance) begin
			was_pressed_q <= ~levels_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (advance && !levels_s1[i] && !was_pressed_q[i]) begin
				press_time_q[i] <= now_s1;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			held[i] = now_s1 - press_time_q[i];
			ev_mask[i] = levels_s1[i] && was_pressed_q[i] &&
				(held[i] > TIME_BITS'(debounce_limit));
			ev_long[i] = (held[i] > TIME_BITS'(long_press_limit)) && long_press_enable[i];
		end
	end

	assign valid_s1 = valid_q;

endmodule

FILE: src/bpc_out_buf.sv
// Result register that sends the events of one tick in ascending button order.
module bpc_out_buf #(
	parameter int NUM_BUTTONS = 4,
	parameter int BUTTON_W = 2
) (
	input logic clk,
	input logic arst_n,
	input logic load,
	input logic [NUM_BUTTONS-1:0] ev_mask,
	input logic [NUM_BUTTONS-1:0] ev_long,
	input logic out_ready,
	output logic out_valid,
	output logic [BUTTON_W-1:0] button,
	output logic long_press,
	output logic last,
	output logic free
);

	logic [NUM_BUTTONS-1:0] mask_q;
	logic [NUM_BUTTONS-1:0] long_q;
	logic [NUM_BUTTONS-1:0] rest;

	assign rest = mask_q & (mask_q - NUM_BUTTONS'(1));
	assign out_valid = |mask_q;
	assign last = (rest == '0);
	assign free = !out_valid || (out_ready && last);

	always_comb begin
		button = '0;
		long_press = 1'b0;
		for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				button = BUTTON_W'(i);
				long_press = long_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= ev_mask;
		end else if (out_valid && out_ready) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			long_q <= ev_long;
		end
	end

endmodule

FILE: src/button_press_classifier.sv
// Top level of the button press classifier.
// The tick channel takes one poll tick per transfer: active-low pin levels and a
// microsecond timestamp. On a release whose held time exceeds the debounce limit,
// one event leaves on the result channel with the button index, a long-press flag
// and a flag on the final event of the tick.
// A tick is captured in an input register, where it is classified, and its
// events then load the result register, from which the first event is offered.
// The result register sends one event per cycle while the receiver is ready;
// ticks with at most one event are taken every cycle while the receiver is
// ready. Ticks without events produce nothing.
// A new tick is taken while the result register still offers events, as long as
// the input register can move on; when the receiver stalls, the result register
// holds, the input register holds, and then the tick channel deasserts ready.
// The configuration port writes one register per cycle with no wait and should
// only be written while the block is idle.
// Reset returns the limits to 12000 us and 600000 us, the enable mask to
// buttons zero and two, and all buttons to released.
module button_press_classifier #(
	parameter int NUM_BUTTONS = 4,
	parameter int TIME_BITS = 48
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input bpc_pkg::cfg_index_t wr_index,
	input bpc_pkg::cfg_data_t wr_data,
	bpc_tick_if.sink tick,
	bpc_event_if.source result
);

	localparam int BUTTON_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	bpc_pkg::cfg_wr_t wr;
	bpc_pkg::limit_t debounce_limit;
	bpc_pkg::limit_t long_press_limit;
	logic [NUM_BUTTONS-1:0] long_press_enable;
	logic valid_s1;
	logic [NUM_BUTTONS-1:0] ev_mask;
	logic [NUM_BUTTONS-1:0] ev_long;
	logic res_free;
	logic advance;
	logic load;

	assign wr = '{we: wr_en, index: wr_index, data: wr_data};
	assign advance = valid_s1 && res_free;
	assign tick.ready = !valid_s1 || res_free;
	assign load = tick.valid && tick.ready;

	bpc_cfg_regs #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.debounce_limit(debounce_limit),
		.long_press_limit(long_press_limit),
		.long_press_enable(long_press_enable)
	);

	bpc_classify #(
		.NUM_BUTTONS(NUM_BUTTONS),
		.TIME_BITS(TIME_BITS)
	) u_classify (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.pin_levels(tick.pin_levels),
		.now_us(tick.now_us),
		.advance(advance),
		.debounce_limit(debounce_limit),
		.long_press_limit(long_press_limit),
		.long_press_enable(long_press_enable),
		.valid_s1(valid_s1),
		.ev_mask(ev_mask),
		.ev_long(ev_long)
	);

	bpc_out_buf #(
		.NUM_BUTTONS(NUM_BUTTONS),
		.BUTTON_W(BUTTON_W)
	) u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance),
		.ev_mask(ev_mask),
		.ev_long(ev_long),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.button(result.button),
		.long_press(result.long_press),
		.last(result.last),
		.free(res_free)
	);

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result.last |=> result.valid)
		else $error("events of a tick stopped before its last event");

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result.last |=>
		result.button > $past(result.button))
		else $error("events of a tick left out of ascending button order");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !res_free |=> valid_s1 && $stable(ev_mask))
		else $error("pending tick lost its events while the result register was busy");
`endif

endmodule
